@@ src/base64_stream_decoder_macros.svh @@
// Assertion macros for the Base64 stream decoder.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define B64SD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define B64SD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/b64sd_pkg.sv @@
// Shared types and constants for the Base64 stream decoder.
// No dependencies.
`default_nettype none

package b64sd_pkg;

	localparam int B64SD_QUEUE_DEPTH = 4;
	localparam int B64SD_MAX_RESULTS = 3;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       last;
	} out_item_t;

	// Results caused by one character: count entries of res are meaningful, from res[0].
	typedef struct packed {
		logic [1:0]      count;
		out_item_t [2:0] res;
	} bundle_t;

endpackage

`default_nettype wire

@@ src/b64sd_decode.sv @@
// Symbol decode and group state of the Base64 stream decoder.
// Depends on b64sd_pkg.
`default_nettype none

module b64sd_decode import b64sd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     fire,
	input  in_item_t item,
	output bundle_t  bundle
);

	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CH_DIG_0 = 8'h30;
	localparam logic [7:0] CH_DIG_9 = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef struct packed {
		logic       hit;
		logic [5:0] value;
	} sym_t;

	function automatic sym_t sym_lookup(input logic [7:0] c);
		sym_t s;
		s.hit   = 1'b1;
		s.value = 6'd0;
		priority if (c >= CH_UP_A && c <= CH_UP_Z)
			s.value = 6'(c - CH_UP_A);
		else if (c >= CH_LO_A && c <= CH_LO_Z)
			s.value = 6'(c - CH_LO_A + 8'd26);
		else if (c >= CH_DIG_0 && c <= CH_DIG_9)
			s.value = 6'(c - CH_DIG_0 + 8'd52);
		else if (c == CH_PLUS)
			s.value = 6'd62;
		else if (c == CH_SLASH)
			s.value = 6'd63;
		else
			s.hit = 1'b0;
		return s;
	endfunction

	// Three bytes of a group, first byte in the top bits.
	function automatic logic [23:0] group_bytes(input logic [5:0] s0, input logic [5:0] s1,
			input logic [5:0] s2, input logic [5:0] s3);
		logic [7:0] b0, b1, b2;
		b0 = {s0, 2'((s1 & 6'h30) >> 4)};
		b1 = {4'(s1 & 6'h0F), 4'((s2 & 6'h3C) >> 2)};
		b2 = {2'(s2 & 6'h03), s3};
		return {b0, b1, b2};
	endfunction

	logic [5:0] store_q [3];
	logic [1:0] count_q;
	logic       stopped_q;

	logic [5:0]  store_d [3];
	logic [1:0]  count_d;
	logic        stopped_d;
	sym_t        sym;
	logic [23:0] grp;

	always_comb begin
		sym       = sym_lookup(item.char_code);
		store_d   = store_q;
		count_d   = count_q;
		stopped_d = stopped_q;
		bundle    = '0;
		grp       = '0;

		if (!stopped_q) begin
			if (!sym.hit) begin
				stopped_d = 1'b1;
			end else if (count_q == 2'd3) begin
				grp = group_bytes(store_q[0], store_q[1], store_q[2], sym.value);
				bundle.count = 2'd3;
				bundle.res[0] = '{data_byte: grp[23:16], byte_valid: 1'b1, last: 1'b0};
				bundle.res[1] = '{data_byte: grp[15:8], byte_valid: 1'b1, last: 1'b0};
				bundle.res[2] = '{data_byte: grp[7:0], byte_valid: 1'b1,
					last: item.end_of_text};
				count_d = 2'd0;
				for (int k = 0; k < 3; k++)
					store_d[k] = 6'd0;
			end else begin
				store_d[count_q] = sym.value;
				count_d = count_q + 2'd1;
			end
		end

		if (item.end_of_text) begin
			if (bundle.count == 2'd0) begin
				if (count_d >= 2'd2) begin
					grp = group_bytes(store_d[0], store_d[1],
						(count_d == 2'd3) ? store_d[2] : 6'd0, 6'd0);
					bundle.count = count_d - 2'd1;
					bundle.res[0] = '{data_byte: grp[23:16], byte_valid: 1'b1,
						last: (count_d == 2'd2)};
					bundle.res[1] = '{data_byte: grp[15:8], byte_valid: 1'b1, last: 1'b1};
				end else begin
					bundle.count = 2'd1;
					bundle.res[0] = '{data_byte: 8'd0, byte_valid: 1'b0, last: 1'b1};
				end
			end
			for (int k = 0; k < 3; k++)
				store_d[k] = 6'd0;
			count_d   = 2'd0;
			stopped_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++)
				store_q[k] <= 6'd0;
			count_q   <= 2'd0;
			stopped_q <= 1'b0;
		end else if (fire) begin
			store_q   <= store_d;
			count_q   <= count_d;
			stopped_q <= stopped_d;
		end
	end

endmodule

`default_nettype wire

@@ src/b64sd_queue.sv @@
// Result queue: takes up to three results a cycle, hands out one a cycle while res_ready is high.
// Depends on b64sd_pkg.
`default_nettype none

module b64sd_queue import b64sd_pkg::*; #(
	parameter int DEPTH = B64SD_QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  bundle_t                      bundle,
	output logic [$clog2(DEPTH+1)-1:0]   free,
	output logic                         res_valid,
	input  logic                         res_ready,
	output out_item_t                    res_item
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int OCC_W = $clog2(DEPTH + 1);

	out_item_t        entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [OCC_W-1:0] occ_q;
	logic             pop;
	logic [1:0]       n_push;

	// Pointer plus small offset, modulo DEPTH (DEPTH must be at least three; the block does not enforce it).
	function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
			input logic [1:0] k);
		logic [PTR_W:0] sum;
		sum = {1'b0, p} + (PTR_W+1)'(k);
		if (sum >= (PTR_W+1)'(DEPTH))
			sum = sum - (PTR_W+1)'(DEPTH);
		return sum[PTR_W-1:0];
	endfunction

	assign pop       = res_valid && res_ready;
	assign n_push    = push ? bundle.count : 2'd0;
	assign res_valid = (occ_q != '0);
	assign res_item  = entries_q[rd_ptr_q];
	assign free      = OCC_W'(DEPTH) - occ_q;

	always_ff @(posedge clk) begin
		for (int k = 0; k < B64SD_MAX_RESULTS; k++) begin
			if (2'(k) < n_push)
				entries_q[ptr_add(wr_ptr_q, 2'(k))] <= bundle.res[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			wr_ptr_q <= ptr_add(wr_ptr_q, n_push);
			if (pop)
				rd_ptr_q <= ptr_add(rd_ptr_q, 2'd1);
			occ_q <= occ_q + OCC_W'(n_push) - OCC_W'(pop);
		end
	end

endmodule

`default_nettype wire

@@ src/base64_stream_decoder.sv @@
// Top level of the Base64 stream decoder: input register, decode, result queue.
// Depends on b64sd_pkg, b64sd_decode, b64sd_queue and the assertion macro header.
//
// Usage:
//   src channel: one encoded character per transaction (src_item.char_code), with
//     src_item.end_of_text set on the final character of a stream.
//   res channel: one decoded byte per transaction. byte_valid=0 marks an empty end
//     marker; last=1 flags the final result of each stream.
//   Standard alphabet only. The first '=' or foreign character stops decoding; the
//   remaining characters up to end_of_text are swallowed.
// Path: an accepted character is held in the input register and decoded from there;
//   its results are written into the queue when it moves on and are offered on res from it.
// Throughput: one character per cycle. A completed group or an end-of-stream flush
//   gives up to three results, which leave the queue one per cycle; the decode
//   stage holds a character while the queue lacks room for all of its results.
// Reset: arst_n clears the group state, the input valid flag and the queue pointers.
// Stall: while res_ready is low the queue fills; once it cannot take the results of
//   the registered character, src_ready drops until results drain.
`default_nettype none

`include "base64_stream_decoder_macros.svh"

module base64_stream_decoder import b64sd_pkg::*; #(
	parameter int QUEUE_DEPTH = B64SD_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_ready,
	input  in_item_t  src_item,
	output logic      res_valid,
	input  logic      res_ready,
	output out_item_t res_item
);

	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

	// Input register stage
	in_item_t item_s1;
	logic     valid_s1;

	bundle_t          bundle;
	logic [OCC_W-1:0] queue_free;
	logic             fire;

	// The registered character moves on only when all its results fit the queue.
	assign fire      = valid_s1 && (OCC_W'(bundle.count) <= queue_free);
	assign src_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_ready) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && src_ready)
			item_s1 <= src_item;
	end

	b64sd_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.bundle (bundle)
	);

	b64sd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.bundle    (bundle),
		.free      (queue_free),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

	// Every stream must close with at least one result.
	`B64SD_ASSERT_IMP(a_eot_gives_result, fire && item_s1.end_of_text, bundle.count != 2'd0, "end of stream produced no result")
	// A full group on the final character marks its third byte as last.
	`B64SD_ASSERT_IMP(a_group_last, fire && bundle.count == 2'd3, !item_s1.end_of_text || bundle.res[2].last, "final group not marked last")
	// Queue can only fill when a character is decoded.
	`B64SD_ASSERT_NXT(a_fill_only_on_fire, !fire, queue_free >= $past(queue_free), "queue filled without a decode")

endmodule

`default_nettype wire
